@@ src/span_bin_free_run_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Span bin allocator assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPAN_BIN_FREE_RUN_ALLOCATOR_DEFINES_SVH
`define SPAN_BIN_FREE_RUN_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBFR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sbfr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sbfr assertion failed");

`endif

@@ src/sbfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sbfr_pkg
// Types, codes and sizes shared by the span bin allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sbfr_pkg;

    localparam int MAX_BINS  = 1024;
    localparam int IDX_W     = $clog2(MAX_BINS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int NODE_W    = 2 * CNT_W;
    localparam int OFFSET_W  = 26;
    localparam int SIZE_W    = 17;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = $clog2(OFFSET_W + 1);
    localparam int PROD_W    = IDX_W + SIZE_W;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;

    // Head code that marks an empty free list.
    localparam logic [CNT_W-1:0] NO_BIN = CNT_W'(MAX_BINS);

    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CARVE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_NO_BIN     = 3'd1,
        STAT_MISALIGNED = 3'd2,
        STAT_RANGE      = 3'd3,
        STAT_NONE_ALLOC = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_EXEC,
        S_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic ready;
        logic accept;
        logic read_node;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_valid;
        t_cmd in_cmd;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ src/sbfr_ram.sv @@
// ----------------------------------------------------------------------------
// sbfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfr_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/sbfr_div.sv @@
// ----------------------------------------------------------------------------
// sbfr_div
// Restoring divider, one quotient bit per cycle, offset by bin size.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfr_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sbfr_pkg::OFFSET_W-1:0] i_dividend,
    input  wire logic [sbfr_pkg::SIZE_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic      [sbfr_pkg::OFFSET_W-1:0] o_quotient,
    output logic      [sbfr_pkg::SIZE_W-1:0]   o_remainder
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [sbfr_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [sbfr_pkg::OFFSET_W-1:0]  r_quo, n_quo;
    logic [sbfr_pkg::SIZE_W-1:0]    r_rem, n_rem;
    logic [sbfr_pkg::SIZE_W-1:0]    r_dsr, n_dsr;
    logic [sbfr_pkg::SIZE_W:0]      w_shift;
    logic                           w_fit;

    // The remainder stays below the divisor, so one extra bit covers the shift.
    assign w_shift = {r_rem, r_quo[sbfr_pkg::OFFSET_W-1]};
    assign w_fit   = (w_shift >= {1'b0, r_dsr});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = sbfr_pkg::DIV_CNT_W'(sbfr_pkg::OFFSET_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[sbfr_pkg::OFFSET_W-2:0], w_fit};
            if (w_fit) begin
                n_rem = sbfr_pkg::SIZE_W'(w_shift - {1'b0, r_dsr});
            end else begin
                n_rem = w_shift[sbfr_pkg::SIZE_W-1:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == sbfr_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

@@ src/sbfr_datapath.sv @@
// ----------------------------------------------------------------------------
// sbfr_datapath
// Free-list head, counters, run-node memory, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfr_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sbfr_pkg::t_dp_cmd              i_cmd,
    output sbfr_pkg::t_dp_stat                  o_stat,
    input  wire logic                           i_cfg_we,
    input  wire logic [sbfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sbfr_pkg::SIZE_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic [sbfr_pkg::S_TDATA_W-1:0] i_in_data,
    input  wire logic [sbfr_pkg::CMD_W-1:0]     i_in_user,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [sbfr_pkg::M_TDATA_W-1:0] o_out_data,
    output logic      [sbfr_pkg::STATUS_W-1:0]  o_out_user
);

    localparam int PAD_W = sbfr_pkg::M_TDATA_W - sbfr_pkg::IDX_W - sbfr_pkg::OFFSET_W
                           - sbfr_pkg::CNT_W - 3;

    // Configuration.
    logic [sbfr_pkg::CNT_W-1:0]    r_bin_count;
    logic [sbfr_pkg::SIZE_W-1:0]   r_bin_size;
    logic [sbfr_pkg::SIZE_W-1:0]   w_bs;

    // Allocator state.
    logic [sbfr_pkg::CNT_W-1:0]    r_head, n_head;
    logic [sbfr_pkg::CNT_W-1:0]    r_used, n_used;
    logic [sbfr_pkg::CNT_W-1:0]    r_span, n_span;

    // Current item and pending result.
    sbfr_pkg::t_cmd                r_op;
    logic [sbfr_pkg::PROD_W-1:0]   r_prod;
    sbfr_pkg::t_status             r_p_status, n_p_status;
    logic [sbfr_pkg::IDX_W-1:0]    r_p_idx, n_p_idx;
    logic [sbfr_pkg::OFFSET_W-1:0] r_p_off, n_p_off;
    logic                          r_p_partial, n_p_partial;
    logic                          r_p_empty, n_p_empty;

    // Result register.
    logic                          r_out_valid, n_out_valid;
    logic [sbfr_pkg::M_TDATA_W-1:0] r_out_data;
    logic [sbfr_pkg::STATUS_W-1:0] r_out_user;

    // Node memory and divider.
    logic                          w_we;
    logic [sbfr_pkg::IDX_W-1:0]    w_waddr;
    logic [sbfr_pkg::NODE_W-1:0]   w_wdata;
    logic [sbfr_pkg::NODE_W-1:0]   w_rdata;
    logic [sbfr_pkg::CNT_W-1:0]    w_len;
    logic [sbfr_pkg::CNT_W-1:0]    w_nxt;
    logic [sbfr_pkg::CNT_W-1:0]    w_head_inc;
    logic [sbfr_pkg::CNT_W-1:0]    w_carve_n;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [sbfr_pkg::OFFSET_W-1:0] w_quo;
    logic [sbfr_pkg::SIZE_W-1:0]   w_rem;
    logic                          w_out_free;

    always_comb begin
        if (r_bin_size < sbfr_pkg::SIZE_MIN) begin
            w_bs = sbfr_pkg::SIZE_MIN;
        end else if (r_bin_size > sbfr_pkg::SIZE_MAX) begin
            w_bs = sbfr_pkg::SIZE_MAX;
        end else begin
            w_bs = r_bin_size;
        end
    end

    assign w_div_start = i_cmd.accept && (sbfr_pkg::t_cmd'(i_in_user) == sbfr_pkg::CMD_FREE);

    sbfr_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (i_in_data[sbfr_pkg::OFFSET_W-1:0]),
        .i_divisor   (w_bs),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    sbfr_ram #(
        .WIDTH (sbfr_pkg::NODE_W),
        .DEPTH (sbfr_pkg::MAX_BINS)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.read_node),
        .i_raddr (r_head[sbfr_pkg::IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // A node holds the run length in the low half and the next run above it.
    assign w_len      = w_rdata[sbfr_pkg::CNT_W-1:0];
    assign w_nxt      = w_rdata[sbfr_pkg::NODE_W-1:sbfr_pkg::CNT_W];
    assign w_head_inc = r_head + 1'b1;
    assign w_carve_n  = (r_bin_count > sbfr_pkg::NO_BIN) ? sbfr_pkg::NO_BIN : r_bin_count;

    always_comb begin
        n_head      = r_head;
        n_used      = r_used;
        n_span      = r_span;
        n_p_status  = r_p_status;
        n_p_idx     = r_p_idx;
        n_p_off     = r_p_off;
        n_p_partial = r_p_partial;
        n_p_empty   = r_p_empty;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        if (i_cmd.exec) begin
            n_p_status  = sbfr_pkg::STAT_OK;
            n_p_idx     = '0;
            n_p_off     = '0;
            n_p_partial = 1'b0;
            n_p_empty   = 1'b0;
            case (r_op)
                sbfr_pkg::CMD_ALLOC: begin
                    if (r_head == sbfr_pkg::NO_BIN) begin
                        n_p_status = sbfr_pkg::STAT_NO_BIN;
                    end else begin
                        // Split the head run, or step to the next run when it
                        // is a single bin or would run past the last node.
                        if ((w_len > sbfr_pkg::CNT_W'(1)) && (w_head_inc < sbfr_pkg::NO_BIN)) begin
                            w_we    = 1'b1;
                            w_waddr = w_head_inc[sbfr_pkg::IDX_W-1:0];
                            w_wdata = {w_nxt, w_len - 1'b1};
                            n_head  = w_head_inc;
                        end else begin
                            n_head = (w_nxt > sbfr_pkg::NO_BIN) ? sbfr_pkg::NO_BIN : w_nxt;
                        end
                        if (r_used < sbfr_pkg::NO_BIN) begin
                            n_used = r_used + 1'b1;
                        end
                        n_p_idx = r_head[sbfr_pkg::IDX_W-1:0];
                        n_p_off = r_prod[sbfr_pkg::OFFSET_W-1:0];
                    end
                end
                sbfr_pkg::CMD_FREE: begin
                    if (w_rem != '0) begin
                        n_p_status = sbfr_pkg::STAT_MISALIGNED;
                    end else if (w_quo >= sbfr_pkg::OFFSET_W'(r_span)) begin
                        n_p_status = sbfr_pkg::STAT_RANGE;
                    end else if (r_used == '0) begin
                        n_p_status = sbfr_pkg::STAT_NONE_ALLOC;
                        n_p_idx    = w_quo[sbfr_pkg::IDX_W-1:0];
                    end else begin
                        w_we        = 1'b1;
                        w_waddr     = w_quo[sbfr_pkg::IDX_W-1:0];
                        w_wdata     = {r_head, sbfr_pkg::CNT_W'(1)};
                        n_head      = {1'b0, w_quo[sbfr_pkg::IDX_W-1:0]};
                        n_used      = r_used - 1'b1;
                        n_p_idx     = w_quo[sbfr_pkg::IDX_W-1:0];
                        n_p_partial = (r_head == sbfr_pkg::NO_BIN);
                        n_p_empty   = (r_used == sbfr_pkg::CNT_W'(1));
                    end
                end
                sbfr_pkg::CMD_CARVE: begin
                    n_span = w_carve_n;
                    n_used = '0;
                    if (w_carve_n == '0) begin
                        n_head = sbfr_pkg::NO_BIN;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                        w_wdata = {sbfr_pkg::NO_BIN, w_carve_n};
                        n_head  = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= sbfr_pkg::CNT_W'(1024);
            r_bin_size  <= sbfr_pkg::SIZE_W'(16);
            r_head      <= sbfr_pkg::NO_BIN;
            r_used      <= '0;
            r_span      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sbfr_pkg::REG_BIN_COUNT: r_bin_count <= i_cfg_data[sbfr_pkg::CNT_W-1:0];
                    sbfr_pkg::REG_BIN_SIZE:  r_bin_size  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_head      <= n_head;
            r_used      <= n_used;
            r_span      <= n_span;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= sbfr_pkg::t_cmd'(i_in_user);
        end
        if (i_cmd.read_node) begin
            r_prod <= sbfr_pkg::PROD_W'(r_head[sbfr_pkg::IDX_W-1:0]) * sbfr_pkg::PROD_W'(w_bs);
        end
        r_p_status  <= n_p_status;
        r_p_idx     <= n_p_idx;
        r_p_off     <= n_p_off;
        r_p_partial <= n_p_partial;
        r_p_empty   <= n_p_empty;
        if (i_cmd.load_out) begin
            r_out_user <= r_p_status;
            r_out_data <= {PAD_W'(0), r_p_empty, r_p_partial, (r_head == sbfr_pkg::NO_BIN),
                           r_used, r_p_off, r_p_idx};
        end
    end

    assign o_stat.in_valid = i_in_valid;
    assign o_stat.in_cmd   = sbfr_pkg::t_cmd'(i_in_user);
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

`default_nettype wire

@@ src/sbfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbfr_ctrl
// Sequencer for one item: accept, any node read or divide, update, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sbfr_pkg::t_dp_stat i_stat,
    output sbfr_pkg::t_dp_cmd       o_cmd
);

    sbfr_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbfr_pkg::S_IDLE: begin
                if (i_stat.in_valid) begin
                    case (i_stat.in_cmd)
                        sbfr_pkg::CMD_ALLOC: n_state = sbfr_pkg::S_READ;
                        sbfr_pkg::CMD_FREE:  n_state = sbfr_pkg::S_DIV;
                        default:             n_state = sbfr_pkg::S_EXEC;
                    endcase
                end
            end
            sbfr_pkg::S_READ: n_state = sbfr_pkg::S_EXEC;
            sbfr_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = sbfr_pkg::S_EXEC;
                end
            end
            sbfr_pkg::S_EXEC: n_state = sbfr_pkg::S_DONE;
            sbfr_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = sbfr_pkg::S_IDLE;
                end
            end
            default: n_state = sbfr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            sbfr_pkg::S_IDLE: begin
                o_cmd.ready  = 1'b1;
                o_cmd.accept = i_stat.in_valid;
            end
            sbfr_pkg::S_READ: o_cmd.read_node = 1'b1;
            sbfr_pkg::S_EXEC: o_cmd.exec = 1'b1;
            sbfr_pkg::S_DONE: o_cmd.load_out = i_stat.out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbfr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ src/span_bin_free_run_allocator.sv @@
// ----------------------------------------------------------------------------
// span_bin_free_run_allocator
// Free-run bin allocator for one span of equal-sized bins.
// ----------------------------------------------------------------------------
// The block takes one command item at a time and returns one result item for
// each. After an allocate is accepted, the run node at the list head is read
// from the node RAM, the list is updated, and the result is loaded. The input
// reopens only once the result is loaded. Carve and no-op skip the node read.
// A free first runs the bit-serial divider that turns the byte offset into a
// bin index. That takes 26 steps, and a registered flag marks completion. The
// result register lets the next item be accepted while a result waits for the
// downstream side. That item then holds in its last step until the register
// frees up. The node RAM needs no clearing after reset; the span is usable
// after the first carve.
`default_nettype none

module span_bin_free_run_allocator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration writes: index 0 bin_count, index 1 bin_size.
    input  wire logic                           i_cfg_we,
    input  wire logic [sbfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sbfr_pkg::SIZE_W-1:0]    i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [25:0] byte_offset, [31:26] zero.
    input  wire logic [sbfr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd.
    input  wire logic [sbfr_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [9:0] bin_index, [35:10] alloc_offset, [46:36] bins_in_use,
    // [47] span_full, [48] became_partial, [49] span_emptied, [55:50] zero.
    output logic      [sbfr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] status.
    output logic      [sbfr_pkg::STATUS_W-1:0]  m_axis_tuser
);

    sbfr_pkg::t_dp_cmd  w_cmd;
    sbfr_pkg::t_dp_stat w_stat;

    sbfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sbfr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

    assign s_axis_tready = w_cmd.ready;

endmodule

`default_nettype wire

@@ src/sbfr_checker.sv @@
// ----------------------------------------------------------------------------
// sbfr_checker
// Port-level assertions for the span bin allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "span_bin_free_run_allocator_defines.svh"

module sbfr_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [sbfr_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A waiting result is not withdrawn.
    `SBFR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // Only one item is worked on at a time, so an accept closes the input.
    `SBFR_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A free that reopens a full span leaves at least one free bin.
    `SBFR_ASSERT_SAME(a_partial_not_full, m_axis_tvalid && m_axis_tdata[48], !m_axis_tdata[47])

    // An emptied span reports no bin in use.
    `SBFR_ASSERT_SAME(a_empty_count, m_axis_tvalid && m_axis_tdata[49], m_axis_tdata[46:36] == 11'd0)

endmodule

bind span_bin_free_run_allocator sbfr_checker u_sbfr_checker (.*);

`default_nettype wire
